// File: hdl/pal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_RD    = 5'b00100,
    S_RDW   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  localparam int POS_BITS   = 7;
  localparam int VALUE_BITS = 32;
  localparam int IN_BITS    = 48;
  localparam int OUT_BITS   = 40;

endpackage

`default_nettype wire

// File: hdl/pal_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/positional_array_list.sv
// Ordered list of up to CAPACITY signed words held in one simple dual-port RAM
// (one write and one read a cycle, registered read), plus an entry count. Each
// item on the in_ stream is an insert, erase or read at a list position and
// gives exactly one item on the out_ stream: success flag, count after the
// operation and the word read (zero unless a read succeeds). Items are handled
// one at a time. An insert or erase moves the later entries one place per cycle
// through the RAM ports before the next item is taken; an insert at the end of
// the list and an erase of the last entry move nothing. A finished item waits
// in the output register while the next item is taken; a stalled output holds
// the following result back. The RAM is not cleared after reset; only entries
// below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module positional_array_list
  import pal_pkg::*;
#(
  parameter int CAPACITY  = 64,
  parameter int DATA_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output      logic                in_tready,
  // cmd[1:0], position[8:2], value[40:9], zero fill above
  input  wire logic [IN_BITS-1:0]  in_tdata,
  output      logic                out_tvalid,
  input  wire logic                out_tready,
  // ok[0], entry_count[7:1], read_value[39:8]
  output      logic [OUT_BITS-1:0] out_tdata
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_BITS) ? CW : POS_BITS;

  logic [1:0]            in_cmd;
  logic [POS_BITS-1:0]   in_pos;
  logic [VALUE_BITS-1:0] in_val;
  assign in_cmd = in_tdata[1:0];
  assign in_pos = in_tdata[8:2];
  assign in_val = in_tdata[40:9];

  state_t state_r, state_nxt;
  logic [CW-1:0]         held_r, held_nxt;
  logic [AW-1:0]         src_r, src_nxt;
  logic [AW-1:0]         last_r, last_nxt;
  logic [AW-1:0]         wdst_r, wdst_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [DATA_BITS-1:0]  val_r, val_nxt;
  logic                  more_r, more_nxt;
  logic                  rv_r, rv_nxt;
  logic                  ins_r, ins_nxt;
  logic                  res_ok_r, res_ok_nxt;
  logic [VALUE_BITS-1:0] res_rd_r, res_rd_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_BITS-1:0]   out_data_r, out_data_nxt;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_BITS-1:0]  ram_wdata, ram_rdata;

  logic [CMPW-1:0] pos_w, held_w;
  logic            accept;

  assign pos_w     = CMPW'(in_pos);
  assign held_w    = CMPW'(held_r);
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  pal_ram #(
    .WIDTH(DATA_BITS),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(src_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    src_nxt       = src_r;
    last_nxt      = last_r;
    wdst_nxt      = wdst_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    more_nxt      = more_r;
    rv_nxt        = 1'b0;
    ins_nxt       = ins_r;
    res_ok_nxt    = res_ok_r;
    res_rd_nxt    = res_rd_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = wdst_r;
    ram_wdata     = ram_rdata;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_ok_nxt = 1'b0;
          res_rd_nxt = '0;
          val_nxt    = DATA_BITS'($signed(in_val));
          pos_nxt    = AW'(pos_w);
          state_nxt  = S_DONE;
          case (in_cmd)
            CMD_INSERT: begin
              if (pos_w <= held_w && held_w < CMPW'(CAPACITY)) begin
                res_ok_nxt = 1'b1;
                held_nxt   = held_r + CW'(1);
                ins_nxt    = 1'b1;
                src_nxt    = AW'(held_w - CMPW'(1));
                last_nxt   = AW'(pos_w);
                more_nxt   = (pos_w != held_w);
                state_nxt  = S_SHIFT;
              end
            end
            CMD_ERASE: begin
              if (pos_w < held_w) begin
                res_ok_nxt = 1'b1;
                held_nxt   = held_r - CW'(1);
                ins_nxt    = 1'b0;
                src_nxt    = AW'(pos_w + CMPW'(1));
                last_nxt   = AW'(held_w - CMPW'(1));
                more_nxt   = 1'b1;
                // erasing the last entry moves nothing
                if (pos_w + CMPW'(1) != held_w) begin
                  state_nxt = S_SHIFT;
                end
              end
            end
            CMD_READ: begin
              if (pos_w < held_w) begin
                res_ok_nxt = 1'b1;
                src_nxt    = AW'(pos_w);
                state_nxt  = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_SHIFT: begin
        // read one entry per cycle, write it one place over in the next cycle
        if (more_r) begin
          ram_re   = 1'b1;
          rv_nxt   = 1'b1;
          wdst_nxt = ins_r ? src_r + AW'(1) : src_r - AW'(1);
          more_nxt = (src_r != last_r);
          src_nxt  = ins_r ? src_r - AW'(1) : src_r + AW'(1);
        end
        if (rv_r) begin
          ram_we    = 1'b1;
          ram_waddr = wdst_r;
          ram_wdata = ram_rdata;
        end else if (!more_r) begin
          if (ins_r) begin
            ram_we    = 1'b1;
            ram_waddr = pos_r;
            ram_wdata = val_r;
          end
          state_nxt = S_DONE;
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_RDW;
      end
      S_RDW: begin
        res_rd_nxt = VALUE_BITS'($signed(ram_rdata));
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {res_rd_r, POS_BITS'(held_r), res_ok_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      more_r      <= 1'b0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      more_r      <= more_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    last_r     <= last_nxt;
    wdst_r     <= wdst_nxt;
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    ins_r      <= ins_nxt;
    res_ok_r   <= res_ok_nxt;
    res_rd_r   <= res_rd_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
